// ----- sv/qet_pkg.sv -----
// ----------------------------------------------------------------------------
// qet_pkg: shared constants, types and tables
// Fixed-point formats, register indexes, easing codes and the logistic table.
// ----------------------------------------------------------------------------
package qet_pkg;

    localparam int DATA_W    = 32;
    localparam int FRAC_BITS = 16;
    localparam int Q_W       = FRAC_BITS + 1;   // values in [0, ONE]

    localparam logic [Q_W-1:0] Q_ONE  = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [Q_W-1:0] Q_HALF = {2'b01, {(FRAC_BITS-1){1'b0}}};

    localparam int SIG_ENTRIES = 256;
    localparam int SIG_IDX_W   = $clog2(SIG_ENTRIES);
    localparam int SIG_LAST    = SIG_ENTRIES - 1;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_START    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_END      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DURATION = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MODE     = 2'd3;

    localparam int MODE_W = 2;
    localparam logic [MODE_W-1:0] MODE_LINEAR  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SMOOTH  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_SIGMOID = 2'd2;

    localparam int DIV_LAT   = Q_W + 1;
    localparam int EASE_LAT  = 3;
    localparam int POLY_LAT  = 3;
    localparam int SCALE_LAT = 2;
    localparam int LATENCY   = DIV_LAT + EASE_LAT + POLY_LAT + SCALE_LAT;

    typedef logic [Q_W-1:0] sig_tab_t [SIG_ENTRIES];

    // Shift-and-subtract quotient, used only while building the table
    function automatic longint unsigned udiv(longint unsigned a, longint unsigned b);
        logic [64:0]     rem;
        longint unsigned q;
        rem = '0;
        q   = '0;
        for (int i = 63; i >= 0; i--) begin
            rem = {rem[63:0], a[i]};
            if (rem >= {1'b0, b}) begin
                rem  = rem - {1'b0, b};
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    // Logistic 0.5*(1+tanh(12*(u-0.5))) sampled at u = i/(N-1), evaluated at
    // elaboration in Q30 through exp series, reciprocal and repeated squaring.
    function automatic sig_tab_t build_sig_tab();
        sig_tab_t tab;
        longint unsigned last;
        longint unsigned twice;
        longint unsigned ad;
        longint unsigned w;
        longint unsigned sum;
        longint unsigned term;
        longint unsigned v;
        longint unsigned den;
        longint unsigned h;
        longint unsigned one;
        longint unsigned q30;
        bit upper;
        last = longint'(SIG_LAST);
        one  = 64'd1 << FRAC_BITS;
        q30  = 64'd1 << 30;
        for (int i = 0; i < SIG_ENTRIES; i++) begin
            twice = 2 * longint'(i);
            upper = (twice >= last);
            ad    = upper ? twice - last : last - twice;
            w     = udiv((3 * ad) << 30, 4 * last);
            sum   = q30;
            term  = q30;
            for (int n = 1; n <= 20; n++) begin
                term = udiv((term * w) >> 30, longint'(n));
                sum  = sum + term;
            end
            v = udiv((64'd1 << 60) + (sum >> 1), sum);
            for (int k = 0; k < 4; k++) begin
                v = (v * v + (q30 >> 1)) >> 30;
            end
            den = q30 + v;
            h   = udiv((one << 30) + (den >> 1), den);
            if (h > one) begin
                h = one;
            end
            tab[i] = upper ? h[Q_W-1:0] : Q_W'(one - h);
        end
        return tab;
    endfunction

    localparam sig_tab_t SIG_TAB = build_sig_tab();

endpackage

// ----- sv/qet_div.sv -----
// ----------------------------------------------------------------------------
// qet_div: pipelined time normalizer
// Clamps the elapsed time to the duration and forms floor(t * ONE / duration)
// with one restoring quotient bit per stage.
// ----------------------------------------------------------------------------
module qet_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic [qet_pkg::DATA_W-1:0]    t,
    input  logic [qet_pkg::DATA_W-1:0]    d,
    output logic                          out_valid,
    output logic [qet_pkg::Q_W-1:0]       u
);
    import qet_pkg::*;

    logic                vld_reg [0:Q_W];
    logic [DATA_W:0]     rem_reg [0:Q_W];
    logic [Q_W-1:0]      quo_reg [0:Q_W];

    // Input stage: clamp time to the end of the move
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg[0] <= 1'b0;
        end
        else
        begin
            vld_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg[0] <= {1'b0, (t > d) ? d : t};
        quo_reg[0] <= '0;
    end

    genvar k;
    generate
        for (k = 0; k < Q_W; k++)
        begin : g_stage
            logic [DATA_W:0] trial;
            logic            take;

            always_comb
            begin
                if (k == 0)
                begin
                    trial = rem_reg[k];
                end
                else
                begin
                    trial = {rem_reg[k][DATA_W-1:0], 1'b0};
                end
                take = (trial >= {1'b0, d});
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    vld_reg[k+1] <= 1'b0;
                end
                else
                begin
                    vld_reg[k+1] <= vld_reg[k];
                end
            end

            always_ff @(posedge clk)
            begin
                rem_reg[k+1] <= take ? trial - {1'b0, d} : trial;
                quo_reg[k+1] <= {quo_reg[k][Q_W-2:0], take};
            end
        end
    endgenerate

    assign out_valid = vld_reg[Q_W];
    assign u         = quo_reg[Q_W];

endmodule

// ----- sv/qet_poly.sv -----
// ----------------------------------------------------------------------------
// qet_poly: quintic blend pipeline
// Evaluates x^3 * (6x^2 - 15x + 10) in three stages with rounded products.
// ----------------------------------------------------------------------------
module qet_poly (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  logic [qet_pkg::Q_W-1:0]   x,
    output logic                      out_valid,
    output logic [qet_pkg::Q_W-1:0]   y
);
    import qet_pkg::*;

    localparam int C_W = FRAC_BITS + 6;   // signed width of the inner factor
    localparam int P_W = Q_W + C_W - 1;   // product of x^3 and the factor

    logic [2:0]          vld_reg;
    logic [Q_W-1:0]      x_reg;
    logic [Q_W-1:0]      x2_reg;
    logic [Q_W-1:0]      x3_reg;
    logic [C_W-2:0]      c_reg;
    logic [Q_W-1:0]      y_reg;

    logic [Q_W-1:0]      xc;
    logic [2*Q_W-1:0]    sq;
    logic [2*Q_W-1:0]    cube;
    logic signed [C_W-1:0] c_full;
    logic [P_W-1:0]      prod;
    logic [P_W-FRAC_BITS-1:0] p_rnd;

    always_comb
    begin
        xc     = (x > Q_ONE) ? Q_ONE : x;
        sq     = xc * xc + (2*Q_W)'(Q_HALF);
        cube   = x2_reg * x_reg + (2*Q_W)'(Q_HALF);
        c_full = C_W'(6) * $signed({1'b0, x2_reg})
               + $signed(C_W'(10) * C_W'(Q_ONE))
               - C_W'(15) * $signed({1'b0, x_reg});
        prod   = x3_reg * c_reg + P_W'(Q_HALF);
        p_rnd  = prod[P_W-1:FRAC_BITS];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg  <= xc;
        x2_reg <= sq[FRAC_BITS+Q_W-1:FRAC_BITS];
        x3_reg <= cube[FRAC_BITS+Q_W-1:FRAC_BITS];
        c_reg  <= (c_full < 0) ? '0 : c_full[C_W-2:0];
        y_reg  <= (p_rnd > (P_W-FRAC_BITS)'(Q_ONE)) ? Q_ONE : p_rnd[Q_W-1:0];
    end

    assign out_valid = vld_reg[2];
    assign y         = y_reg;

endmodule

// ----- sv/qet_sig.sv -----
// ----------------------------------------------------------------------------
// qet_sig: logistic easing lookup
// Table lookup with linear interpolation between neighboring entries.
// ----------------------------------------------------------------------------
module qet_sig (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  logic [qet_pkg::Q_W-1:0]   u,
    output logic                      out_valid,
    output logic [qet_pkg::Q_W-1:0]   s
);
    import qet_pkg::*;

    localparam int POS_W = Q_W + SIG_IDX_W;
    localparam int I_W   = POS_W - FRAC_BITS;
    localparam int M_W   = Q_W + FRAC_BITS;

    logic [2:0]            vld_reg;
    logic [POS_W-1:0]      pos_reg;
    logic [Q_W-1:0]        a_reg;
    logic [Q_W-1:0]        diff_reg;
    logic [FRAC_BITS-1:0]  frac_reg;
    logic [Q_W-1:0]        s_reg;

    logic [I_W-1:0]        idx;
    logic [SIG_IDX_W-1:0]  idx_lo;
    logic [SIG_IDX_W-1:0]  idx_hi;
    logic                  at_end;
    logic [Q_W-1:0]        a;
    logic [Q_W-1:0]        b;
    logic [M_W-1:0]        step;

    always_comb
    begin
        idx    = pos_reg[POS_W-1:FRAC_BITS];
        idx_lo = idx[SIG_IDX_W-1:0];
        idx_hi = idx_lo + SIG_IDX_W'(1);
        at_end = (idx >= I_W'(SIG_LAST));
        a      = SIG_TAB[idx_lo];
        b      = SIG_TAB[idx_hi];
        step   = diff_reg * frac_reg + M_W'(Q_HALF);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg  <= POS_W'(u) * POS_W'(SIG_LAST);
        frac_reg <= pos_reg[FRAC_BITS-1:0];
        if (at_end)
        begin
            a_reg    <= SIG_TAB[SIG_LAST];
            diff_reg <= '0;
        end
        else
        begin
            a_reg    <= a;
            diff_reg <= (b < a) ? '0 : b - a;
        end
        s_reg <= a_reg + step[M_W-1:FRAC_BITS];
    end

    assign out_valid = vld_reg[2];
    assign s         = s_reg;

endmodule

// ----- sv/quintic_eased_trajectory_unit.sv -----
// ----------------------------------------------------------------------------
// quintic_eased_trajectory_unit: eased rest-to-rest quintic position generator
// Normalizes elapsed time, applies easing and the quintic blend, and scales.
// ----------------------------------------------------------------------------
// Takes one time sample per clock; done pulses with its position once the
// sample has passed all 26 register stages, the first loaded at the accepting
// edge. Results always leave in order and cannot be held off. The path runs
// through the input register and the 17-stage restoring divider that
// normalizes time (one quotient bit per stage), followed by three easing
// stages, three polynomial stages and two scaling stages. busy stays low. A
// zero duration returns the start position. Write configuration only while
// no transaction is in flight.
module quintic_eased_trajectory_unit (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic [qet_pkg::DATA_W-1:0]           time_elapsed,
    output logic                                 done,
    output logic signed [qet_pkg::DATA_W-1:0]    position,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [qet_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [qet_pkg::DATA_W-1:0]           cfg_data
);
    import qet_pkg::*;

    localparam int R_W = DATA_W + Q_W;

    logic signed [DATA_W-1:0] start_position_reg;
    logic signed [DATA_W-1:0] end_position_reg;
    logic [DATA_W-1:0]        duration_reg;
    logic [MODE_W-1:0]        easing_mode_reg;
    logic [DATA_W-1:0]        mag_reg;
    logic                     neg_reg;

    logic                     u_valid;
    logic [Q_W-1:0]           u_val;
    logic                     sm_valid;
    logic [Q_W-1:0]           sm_val;
    logic                     sig_valid;
    logic [Q_W-1:0]           sig_val;
    logic [Q_W-1:0]           lin_reg [0:EASE_LAT-1];
    logic [Q_W-1:0]           s_val;
    logic                     p_valid;
    logic [Q_W-1:0]           p_val;

    logic                     m_valid_reg;
    logic [R_W-FRAC_BITS-1:0] r_reg;
    logic                     done_reg;
    logic signed [DATA_W-1:0] position_reg;

    logic signed [DATA_W:0]   dx;
    logic [R_W-1:0]           prod;
    logic [DATA_W:0]          sum;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_position_reg <= '0;
            end_position_reg   <= '0;
            duration_reg       <= '0;
            easing_mode_reg    <= MODE_LINEAR;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_START:    start_position_reg <= cfg_data;
                REG_END:      end_position_reg   <= cfg_data;
                REG_DURATION: duration_reg       <= cfg_data;
                REG_MODE:     easing_mode_reg    <= cfg_data[MODE_W-1:0];
                default:      ;
            endcase
        end
    end

    // Move span magnitude and direction, tracked from the registers
    always_comb
    begin
        dx = {end_position_reg[DATA_W-1], end_position_reg}
           - {start_position_reg[DATA_W-1], start_position_reg};
    end

    always_ff @(posedge clk)
    begin
        neg_reg <= dx[DATA_W];
        mag_reg <= dx[DATA_W] ? DATA_W'(-dx) : dx[DATA_W-1:0];
    end

    qet_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start),
        .t         (time_elapsed),
        .d         (duration_reg),
        .out_valid (u_valid),
        .u         (u_val)
    );

    qet_poly u_ease_poly (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (u_valid),
        .x         (u_val),
        .out_valid (sm_valid),
        .y         (sm_val)
    );

    qet_sig u_ease_sig (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (u_valid),
        .u         (u_val),
        .out_valid (sig_valid),
        .s         (sig_val)
    );

    // Delay linear u to line up with the easing units
    always_ff @(posedge clk)
    begin
        lin_reg[0] <= u_val;
        for (int i = 1; i < EASE_LAT; i++)
        begin
            lin_reg[i] <= lin_reg[i-1];
        end
    end

    always_comb
    begin
        case (easing_mode_reg)
            MODE_SMOOTH:  s_val = sm_val;
            MODE_SIGMOID: s_val = sig_val;
            default:      s_val = lin_reg[EASE_LAT-1];
        endcase
    end

    qet_poly u_blend_poly (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sm_valid),
        .x         (s_val),
        .out_valid (p_valid),
        .y         (p_val)
    );

    always_comb
    begin
        prod = mag_reg * p_val + R_W'(Q_HALF);
        if (neg_reg)
        begin
            sum = {start_position_reg[DATA_W-1], start_position_reg}
                - (DATA_W+1)'(r_reg);
        end
        else
        begin
            sum = {start_position_reg[DATA_W-1], start_position_reg}
                + (DATA_W+1)'(r_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            m_valid_reg <= p_valid;
            done_reg    <= m_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        r_reg <= prod[R_W-1:FRAC_BITS];
        if (duration_reg == '0)
        begin
            position_reg <= start_position_reg;
        end
        else
        begin
            position_reg <= sum[DATA_W-1:0];
        end
    end

    assign done     = done_reg;
    assign position = position_reg;

`ifndef SYNTH
    a_blend_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        p_valid |-> (p_val <= Q_ONE))
        else $error("blend factor above one");

    a_sigmoid_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        sig_valid |-> (sig_val <= Q_ONE))
        else $error("logistic easing above one");

    a_done_follows_blend: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(p_valid, SCALE_LAT))
        else $error("done without a blended transaction");
`endif

endmodule
